// ===== rtl/peti_pkg.sv =====
package peti_pkg;
  localparam int unsigned TableSize = 256;
  localparam int unsigned IdxW = $clog2(TableSize);
  localparam int unsigned FracW = 16;
  localparam int unsigned SpanW = 25;
  localparam int unsigned StepW = SpanW - IdxW;

  typedef enum logic [1:0] {
    OpWrite = 2'd0,
    OpLookup = 2'd1,
    OpSync = 2'd2,
    OpNone = 2'd3
  } op_e;

  typedef enum logic {
    CfgMicro = 1'b0,
    CfgFull = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e op;
    logic axis;
    logic [31:0] position;
    logic clockwise;
    logic [7:0] entry_index;
    logic [15:0] entry_value;
  } item_t;

  typedef struct packed {
    logic [7:0] table_index;
    logic [23:0] correction;
  } res_t;

  typedef enum logic [3:0] {
    StIdle, StRem, StRemFix, StDiv, StFloor, StPhase, StRd0, StRd1, StMul, StOut
  } back_state_e;
endpackage

// ===== rtl/peti_queue.sv =====
module peti_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  peti_pkg::item_t in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output peti_pkg::item_t out_item_o
);
  import peti_pkg::*;
  item_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;

  assign in_ready_o = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign push = in_valid_i && in_ready_o;
  assign pop = out_valid_o && out_ready_i;
  assign out_item_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_item_i;
  end
endmodule

// ===== rtl/peti_back.sv =====
module peti_back (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [8:0] micro_i,
  input  logic [15:0] full_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  peti_pkg::item_t in_item_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output peti_pkg::res_t out_res_o
);
  import peti_pkg::*;

  back_state_e state_q, state_d;
  item_t it_q;
  logic [SpanW-1:0] span_q;
  logic [StepW-1:0] step_q;
  logic [63:0] acc_q;
  logic [5:0] cnt_q;
  logic neg_q;
  logic [47:0] quo_q;
  logic [FracW+IdxW-1:0] p_q;
  logic [16:0] ofs_q [2];
  logic [IdxW:0] clr_q;
  logic clr_busy_q;
  logic [15:0] mem_q [2*TableSize];
  logic [15:0] rd_q, base_q;
  logic [IdxW-1:0] nxt_q;
  logic [40:0] prod_q;
  logic out_v_q;
  res_t res_q;

  logic [SpanW:0] trial_r;
  logic [31:0] mag;
  logic [StepW:0] trial_d;
  logic rd_en;
  logic [IdxW:0] rd_addr;
  logic [IdxW-1:0] idx;
  logic [FracW:0] weight;
  logic signed [16:0] diff;
  logic signed [34:0] prod;

  assign mag = in_item_i.position[31] ? (~in_item_i.position + 32'd1) : in_item_i.position;
  assign trial_r = {acc_q[63:63-SpanW+1], acc_q[63-SpanW]} - {1'b0, span_q};
  assign trial_d = acc_q[63:63-StepW] - {1'b0, step_q};
  assign idx = p_q[FracW+IdxW-1:FracW];
  assign weight = it_q.clockwise ? {1'b0, p_q[FracW-1:0]}
                                 : (17'h10000 - {1'b0, p_q[FracW-1:0]});
  assign diff = $signed({rd_q[15], rd_q}) - $signed({base_q[15], base_q});
  assign prod = $signed({1'b0, weight}) * diff;
  assign in_ready_o = state_q == StIdle && !clr_busy_q;
  assign out_valid_o = out_v_q;
  assign out_res_o = res_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (in_valid_i && in_ready_o) begin
        case (in_item_i.op)
          OpLookup, OpSync: state_d = (span_q[SpanW-1:IdxW] == '0) ? StPhase : StRem;
          default: state_d = StOut;
        endcase
      end
      StRem: if (cnt_q == 6'd31) state_d = StRemFix;
      StRemFix: state_d = StDiv;
      StDiv: if (cnt_q == 6'd47) state_d = StFloor;
      StFloor: state_d = StPhase;
      StPhase: state_d = (it_q.op == OpLookup) ? StRd0 : StOut;
      StRd0: state_d = StRd1;
      StRd1: state_d = StMul;
      StMul: state_d = StOut;
      StOut: if (!out_v_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    rd_en = 1'b0;
    rd_addr = {it_q.axis, idx};
    case (state_q)
      StRd0: rd_en = 1'b1;
      StRd1: begin
        rd_en = 1'b1;
        rd_addr = {it_q.axis, nxt_q};
      end
      default: rd_en = 1'b0;
    endcase
  end

  // tables zeroed after reset, one entry after another as clr_q counts up
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) mem_q[clr_q] <= 16'd0;
    else if (state_q == StIdle && in_valid_i && in_ready_o && in_item_i.op == OpWrite)
      mem_q[{in_item_i.axis, in_item_i.entry_index[IdxW-1:0]}] <= in_item_i.entry_value;
    if (rd_en) rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
      clr_q <= '0;
      clr_busy_q <= 1'b1;
      ofs_q[0] <= '0;
      ofs_q[1] <= '0;
      span_q <= '0;
      step_q <= '0;
    end else begin
      state_q <= state_d;
      span_q <= SpanW'(micro_i) * SpanW'(full_i);
      step_q <= span_q[SpanW-1:IdxW];
      if (clr_busy_q) begin
        clr_q <= clr_q + 1'b1;
        if (clr_q == '1) clr_busy_q <= 1'b0;
      end
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      case (state_q)
        StIdle: if (in_valid_i && in_ready_o) begin
          it_q <= in_item_i;
          neg_q <= in_item_i.position[31];
          acc_q <= {25'd0, mag, 7'd0};
          cnt_q <= '0;
          quo_q <= '0;
        end
        StRem: begin
          cnt_q <= cnt_q + 6'd1;
          if (!trial_r[SpanW])
            acc_q <= {trial_r[SpanW-1:0], acc_q[63-SpanW-1:0], 1'b0};
          else acc_q <= {acc_q[62:0], 1'b0};
        end
        StRemFix: begin
          acc_q <= {16'd0, 8'd0, acc_q[63:64-SpanW], 15'd0};
          cnt_q <= '0;
        end
        StDiv: begin
          cnt_q <= cnt_q + 6'd1;
          if (!trial_d[StepW]) begin
            acc_q <= {trial_d[StepW-1:0], acc_q[63-StepW-1:0], 1'b0};
            quo_q <= {quo_q[46:0], 1'b1};
          end else begin
            acc_q <= {acc_q[62:0], 1'b0};
            quo_q <= {quo_q[46:0], 1'b0};
          end
        end
        StFloor: begin
          if (neg_q && it_q.op == OpLookup)
            quo_q <= (~quo_q + 48'd1) - ((acc_q[63:64-StepW] != '0) ? 48'd1 : 48'd0);
        end
        StPhase: begin
          if (it_q.op == OpSync) begin
            if (step_q == '0) ofs_q[it_q.axis] <= '0;
            else if (neg_q) ofs_q[it_q.axis] <= ~quo_q[32:16] + 17'd1;
            else ofs_q[it_q.axis] <= quo_q[32:16];
          end else begin
            p_q <= (step_q == '0) ? (FracW+IdxW)'(0) - {ofs_q[it_q.axis][IdxW-1:0], 16'd0}
                 : quo_q[FracW+IdxW-1:0] - {ofs_q[it_q.axis][IdxW-1:0], 16'd0};
            nxt_q <= '0;
          end
        end
        StRd0: nxt_q <= it_q.clockwise ? idx + 1'b1 : idx - 1'b1;
        StRd1: base_q <= rd_q;
        StMul: prod_q <= 41'(prod);
        StOut: if (!out_v_q) begin
          out_v_q <= 1'b1;
          if (it_q.op == OpLookup) begin
            res_q.table_index <= 8'(idx);
            res_q.correction <= 24'({{8{base_q[15]}}, base_q, 8'd0} +
                                {{8{prod_q[40]}}, prod_q[40:8]} + 41'd0 +
                                ((prod_q[7:0] >= 8'd128) ? 41'd1 : 41'd0));
          end else res_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/periodic_error_table_interpolator.sv =====
// Per item: a write or unused op goes straight to the result; a lookup or sync runs a
// 32-step serial modulo and a 48-step serial divide, and a lookup then two table reads;
// with a degenerate geometry both skip the modulo and divide. One item is worked on at
// a time; the next is taken only once the last has reached its result. A two-entry
// queue buffers input transactions. Reset (rst_ni low, async) clears control and
// offsets; a pass then zeroes both tables, during which the unit takes nothing from the queue.
module periodic_error_table_interpolator (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // position[31:0], clockwise[32], entry_index[40:33], entry_value[56:41]
  input  logic [63:0] s_axis_tdata,
  // op[1:0], axis[2]
  input  logic [2:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // table_index[7:0], correction[31:8]
  output logic [31:0] m_axis_tdata
);
  import peti_pkg::*;
  logic [8:0] micro_q;
  logic [15:0] full_q;
  item_t in_it, q_it;
  res_t res;
  logic q_v, q_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      micro_q <= 9'd16;
      full_q <= 16'd400;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgMicro) micro_q <= cfg_data_i[8:0];
      else full_q <= cfg_data_i;
    end
  end

  assign in_it = '{op: op_e'(s_axis_tuser[1:0]), axis: s_axis_tuser[2],
                   position: s_axis_tdata[31:0], clockwise: s_axis_tdata[32],
                   entry_index: s_axis_tdata[40:33], entry_value: s_axis_tdata[56:41]};

  peti_queue u_q (.clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_item_i(in_it), .out_valid_o(q_v), .out_ready_i(q_r), .out_item_o(q_it));

  peti_back u_b (.clk_i, .rst_ni, .micro_i(micro_q), .full_i(full_q), .in_valid_i(q_v),
    .in_ready_o(q_r), .in_item_i(q_it), .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready), .out_res_o(res));

  assign m_axis_tdata = {res.correction, res.table_index};
endmodule

// ===== rtl/peti_checker.sv =====
module peti_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");
  a_rst: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("valid during reset");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("back to back output");
endmodule

bind periodic_error_table_interpolator peti_checker u_chk (.clk_i, .rst_ni,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);
